@@ rtl/kpld_pkg.sv @@
// Shared constants, codes and types of the keyframe proximity loop detector.
package kpld_pkg;

   localparam int DEF_WINDOW_DEPTH = 20;
   localparam int DEF_COORD_BITS   = 24;

   localparam int DIST_W     = 23;
   localparam int MINKF_W    = 5;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 23;

   localparam logic                 RST_LOOP_ENABLE   = 1'b1;
   localparam logic [MINKF_W-1:0]   RST_MIN_KEYFRAMES = 5'd5;
   localparam logic [DIST_W-1:0]    RST_MAX_DISTANCE  = 23'd12800;
   localparam logic [DIST_W-1:0]    RST_MIN_DISTANCE  = 23'd2560;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_KEYFRAMES = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE  = 4'd3;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] axis;
   } kpld_tag_type;

endpackage

@@ rtl/kpld_if.sv @@
// Channel interfaces: request, response and register write.
interface kpld_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   modport source (output valid, output opcode, output pos_x, output pos_y, output pos_z,
                   input ready);
   modport sink   (input valid, input opcode, input pos_x, input pos_y, input pos_z,
                   output ready);
endinterface

interface kpld_rsp_if;
   logic       valid;
   logic       ready;
   logic       loop_found;
   logic [4:0] stored_count;
   modport source (output valid, output loop_found, output stored_count, input ready);
   modport sink   (input valid, input loop_found, input stored_count, output ready);
endinterface

interface kpld_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  reg_index;
   logic [22:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/keyframe_proximity_loop_detector_unit.sv @@
// Top level: sequencer, registers and scan pipeline of the loop detector.
//
//  channel   dir  handshake        payload
//  req_chan  in   valid / ready    opcode, pos_x, pos_y, pos_z
//  rsp_chan  out  valid / ready    loop_found, stored_count
//  csr_chan  in   valid / ready    reg_index, wdata
//
// An add, or a check that is skipped, goes from the accepting idle state straight to the result state.
// A scanning check first squares both thresholds and then walks the N held keyframes:
// the single squaring unit handles one axis of one keyframe per cycle.
// Synchronous active-high reset clears control state and loads register defaults.
// req_ready is high only while idle; a waiting result holds the sequencer in its last state.
module keyframe_proximity_loop_detector_unit import kpld_pkg::*; #(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   kpld_req_if.sink    req_chan,
   kpld_rsp_if.source  rsp_chan,
   kpld_csr_if.sink    csr_chan
);

   localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W   = (CNT_W > MINKF_W) ? CNT_W : MINKF_W;
   localparam int ENTRY_W = 3 * COORD_BITS;
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int MAG_W   = (DIFF_W > DIST_W) ? DIFF_W : DIST_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int ACC_W   = SQ_W + 2;
   localparam int QW      = ACC_W + 2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQ_MIN = 7'b0000010,
      ST_SQ_MAX = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_FLUSH  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic                loop_enable_ff;
   logic [MINKF_W-1:0]  min_kf_ff;
   logic [DIST_W-1:0]   max_dist_ff;
   logic [DIST_W-1:0]   min_dist_ff;

   logic [ENTRY_W-1:0]  pos_ff;
   logic [IDX_W-1:0]    entry_ff, entry_in;
   logic [1:0]          axis_ff, axis_in;
   logic                found_ff, found_in;
   logic [SQ_W-1:0]     min_sq_ff;
   logic [SQ_W-1:0]     max_sq_ff;

   kpld_tag_type        t1_ff, t2_ff, t3_ff;
   kpld_tag_type        t1_in;
   logic                v4_ff;
   logic [MAG_W-1:0]    diff_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_sum;
   logic [ACC_W-1:0]    d2_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                req_fire;
   logic                rsp_load;
   logic                scan_ok;
   logic                last_issue;
   logic                store_wr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [CNT_W-1:0]    held_count;
   logic [MAG_W-1:0]    sq_mag;
   logic [SQ_W-1:0]     sq;
   logic signed [COORD_BITS-1:0] sel_p;
   logic signed [COORD_BITS-1:0] sel_k;
   logic signed [DIFF_W-1:0]     diff_s;
   logic [DIFF_W-1:0]            diff_abs;

   kpld_kf_store #(
      .DEPTH   (WINDOW_DEPTH),
      .ENTRY_W (ENTRY_W),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (store_wr),
      .wr_data    ({req_chan.pos_z, req_chan.pos_y, req_chan.pos_x}),
      .rd_addr    (entry_ff),
      .rd_data    (rd_data),
      .held_count (held_count)
   );

   kpld_sq_unit #(
      .MAG_W (MAG_W)
   ) u_sq (
      .clock (clock),
      .mag   (sq_mag),
      .sq    (sq)
   );

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_enable_ff <= RST_LOOP_ENABLE;
         min_kf_ff      <= RST_MIN_KEYFRAMES;
         max_dist_ff    <= RST_MAX_DISTANCE;
         min_dist_ff    <= RST_MIN_DISTANCE;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_LOOP_ENABLE:   loop_enable_ff <= csr_chan.wdata[0];
            CSR_MIN_KEYFRAMES: min_kf_ff      <= csr_chan.wdata[MINKF_W-1:0];
            CSR_MAX_DISTANCE:  max_dist_ff    <= csr_chan.wdata[DIST_W-1:0];
            CSR_MIN_DISTANCE:  min_dist_ff    <= csr_chan.wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign store_wr   = req_fire && (req_chan.opcode == OP_ADD);
   assign scan_ok    = loop_enable_ff && (held_count != '0) &&
                       (CMP_W'(held_count) >= CMP_W'(min_kf_ff));
   assign last_issue = (axis_ff == AXIS_Z) &&
                       (CNT_W'(entry_ff) + CNT_W'(1) == held_count);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      axis_in  = axis_ff;
      t1_in    = '0;
      case (state_ff)
         ST_IDLE: begin
            entry_in = '0;
            axis_in  = AXIS_X;
            if (req_fire) begin
               if (req_chan.opcode == OP_CHECK && scan_ok) begin
                  state_in = ST_SQ_MIN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQ_MIN: state_in = ST_SQ_MAX;
         ST_SQ_MAX: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SCAN;
         ST_SCAN: begin
            t1_in.valid = 1'b1;
            t1_in.axis  = axis_ff;
            if (axis_ff == AXIS_Z) begin
               axis_in  = AXIS_X;
               entry_in = entry_ff + IDX_W'(1);
            end else begin
               axis_in  = axis_ff + 2'd1;
            end
            if (last_issue) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!t1_ff.valid && !t2_ff.valid && !t3_ff.valid && !v4_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         t1_ff    <= '0;
         t2_ff    <= '0;
         t3_ff    <= '0;
         v4_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         t1_ff    <= t1_in;
         t2_ff    <= t1_ff;
         t3_ff    <= t2_ff;
         v4_ff    <= t3_ff.valid && (t3_ff.axis == AXIS_Z);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      axis_ff  <= axis_in;
      if (req_fire) begin
         pos_ff <= {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
      end
   end

   // squaring unit source: thresholds first, then coordinate differences
   always_comb begin
      case (state_ff)
         ST_SQ_MIN: sq_mag = MAG_W'(min_dist_ff);
         ST_SQ_MAX: sq_mag = MAG_W'(max_dist_ff);
         default:   sq_mag = diff_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SQ_MAX) begin
         min_sq_ff <= sq;
      end
      if (state_ff == ST_LOAD) begin
         max_sq_ff <= sq;
      end
   end

   // scan pipeline: read, difference, square, accumulate, compare
   always_comb begin
      case (t1_ff.axis)
         AXIS_X: begin
            sel_p = pos_ff[0 +: COORD_BITS];
            sel_k = rd_data[0 +: COORD_BITS];
         end
         AXIS_Y: begin
            sel_p = pos_ff[COORD_BITS +: COORD_BITS];
            sel_k = rd_data[COORD_BITS +: COORD_BITS];
         end
         AXIS_Z: begin
            sel_p = pos_ff[2*COORD_BITS +: COORD_BITS];
            sel_k = rd_data[2*COORD_BITS +: COORD_BITS];
         end
         default: begin
            sel_p = '0;
            sel_k = '0;
         end
      endcase
   end

   assign diff_s   = DIFF_W'(sel_p) - DIFF_W'(sel_k);
   assign diff_abs = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
   assign acc_sum  = ACC_W'(sq) + ((t3_ff.axis == AXIS_X) ? '0 : acc_ff);

   always_ff @(posedge clock) begin
      diff_ff <= MAG_W'(diff_abs);
      if (t3_ff.valid) begin
         acc_ff <= acc_sum;
         if (t3_ff.axis == AXIS_Z) begin
            d2_ff <= acc_sum;
         end
      end
   end

   always_comb begin
      found_in = found_ff;
      if (req_fire) begin
         found_in = 1'b0;
      end else if (v4_ff && (d2_ff > ACC_W'(min_sq_ff)) &&
                   (QW'({d2_ff, 2'b00}) < QW'(max_sq_ff))) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_count_ff <= COUNT_W'(held_count);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.loop_found   = rsp_found_ff;
   assign rsp_chan.stored_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> CNT_W'(entry_ff) < held_count)
      else $error("scan index beyond held keyframes");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !t1_ff.valid && !t2_ff.valid && !t3_ff.valid && !v4_ff)
      else $error("scan pipeline busy while idle");
`endif

endmodule

@@ rtl/kpld_sq_unit.sv @@
// Shared squaring unit: one registered unsigned square per cycle.
module kpld_sq_unit #(
   parameter int MAG_W = 25
) (
   input  logic               clock,
   input  logic [MAG_W-1:0]   mag,
   output logic [2*MAG_W-1:0] sq
);

   logic [2*MAG_W-1:0] sq_ff;
   logic [2*MAG_W-1:0] sq_in;

   assign sq_in = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sq = sq_ff;

endmodule

@@ rtl/kpld_kf_store.sv @@
// Keyframe window memory with fill count and oldest-entry pointer.
module kpld_kf_store #(
   parameter int DEPTH   = 20,
   parameter int ENTRY_W = 72,
   parameter int IDX_W   = 5,
   parameter int CNT_W   = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   output logic [CNT_W-1:0]   held_count
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]   held_ff;
   logic [CNT_W-1:0]   held_in;
   logic [IDX_W-1:0]   oldest_ff;
   logic [IDX_W-1:0]   oldest_in;
   logic [IDX_W-1:0]   wr_slot;
   logic               full;

   assign full = (held_ff == CNT_W'(DEPTH));

   always_comb begin
      held_in   = held_ff;
      oldest_in = oldest_ff;
      wr_slot   = IDX_W'(held_ff);
      if (full) begin
         wr_slot = oldest_ff;
      end
      if (wr_en) begin
         if (!full) begin
            held_in = held_ff + CNT_W'(1);
         end else if (oldest_ff == IDX_W'(DEPTH - 1)) begin
            oldest_in = '0;
         end else begin
            oldest_in = oldest_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         held_ff   <= held_in;
         oldest_ff <= oldest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data    = rd_data_ff;
   assign held_count = held_ff;

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("keyframe count above window depth");

   a_held_grow: assert property (@(posedge clock) disable iff (reset)
      wr_en && !full |=> held_ff == CNT_W'($past(held_ff) + CNT_W'(1)))
      else $error("keyframe count did not grow on add");
`endif

endmodule
